[src/alist_pkg.sv]
package alist_pkg;

   localparam int DEPTH_DEFAULT = 16;
   localparam int IDX_MAX_W     = 10;
   localparam int WORD_W        = 32;
   localparam int MODE_W        = 2;
   localparam int POS_W         = 5;
   localparam int COUNT_W       = 5;

   typedef enum logic [MODE_W-1:0] {
      MODE_PUSH   = 2'd0,
      MODE_POP    = 2'd1,
      MODE_READ   = 2'd2,
      MODE_INSERT = 2'd3
   } mode_type;

   typedef struct packed {
      logic                 wr;
      logic [IDX_MAX_W-1:0] wr_idx;
      logic [IDX_MAX_W-1:0] rd_idx;
   } cell_ctl_type;

endpackage

[src/array_list_insert_stack.sv]
// Channel   Direction  Handshake            Payload
// req_      in         req_valid/req_stall  req_mode, req_position, req_value
// rsp_      out        rsp_valid/rsp_stall  rsp_ok, rsp_data, rsp_count
//
// One transaction per cycle unless stalled; response comes the next cycle.
// A row of DEPTH entry cells shifts on insert in that same cycle; reads pick
// one cell through an OR of the cell outputs.
// Synchronous reset empties the list; entries hold no reset value.
// A stalled response holds the output register and stalls the request side.
module array_list_insert_stack #(
   parameter int DEPTH = alist_pkg::DEPTH_DEFAULT
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic [alist_pkg::MODE_W-1:0]         req_mode,
   input  logic [alist_pkg::POS_W-1:0]          req_position,
   input  logic signed [alist_pkg::WORD_W-1:0]  req_value,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic                                 rsp_ok,
   output logic signed [alist_pkg::WORD_W-1:0]  rsp_data,
   output logic [alist_pkg::COUNT_W-1:0]        rsp_count
);

   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam int CMP_W = ((CNT_W > alist_pkg::POS_W) ? CNT_W : alist_pkg::POS_W) + 1;

   logic [CNT_W-1:0]                    fill_count_ff;
   logic [CNT_W-1:0]                    fill_count_in;
   logic                                rsp_valid_ff;
   logic                                rsp_valid_in;
   logic                                rsp_ok_ff;
   logic                                rsp_ok_in;
   logic signed [alist_pkg::WORD_W-1:0] rsp_data_ff;
   logic signed [alist_pkg::WORD_W-1:0] rsp_data_in;
   logic [alist_pkg::COUNT_W-1:0]       rsp_count_ff;
   logic [alist_pkg::COUNT_W-1:0]       rsp_count_in;

   logic                                req_accept;
   logic                                ok;
   logic                                rd_sel;
   logic [CMP_W-1:0]                    cnt_ext;
   logic [CMP_W-1:0]                    pos_ext;
   logic [CMP_W-1:0]                    depth_ext;
   alist_pkg::cell_ctl_type             ctl;
   logic signed [alist_pkg::WORD_W-1:0] rd_or;

   logic signed [alist_pkg::WORD_W-1:0] cell_entry [DEPTH];
   logic signed [alist_pkg::WORD_W-1:0] cell_rd    [DEPTH];

   assign req_stall  = rsp_valid_ff && rsp_stall;
   assign req_accept = req_valid && !req_stall;

   assign cnt_ext   = CMP_W'(fill_count_ff);
   assign pos_ext   = CMP_W'(req_position);
   assign depth_ext = CMP_W'(DEPTH);

   always_comb begin
      ok            = 1'b0;
      rd_sel        = 1'b0;
      ctl.wr        = 1'b0;
      ctl.wr_idx    = '0;
      ctl.rd_idx    = '0;
      fill_count_in = fill_count_ff;
      unique case (alist_pkg::mode_type'(req_mode))
         alist_pkg::MODE_PUSH: begin
            ok         = cnt_ext < depth_ext;
            ctl.wr_idx = alist_pkg::IDX_MAX_W'(fill_count_ff);
            if (ok) begin
               fill_count_in = fill_count_ff + CNT_W'(1);
            end
         end
         alist_pkg::MODE_POP: begin
            ok         = cnt_ext != '0;
            rd_sel     = 1'b1;
            ctl.rd_idx = alist_pkg::IDX_MAX_W'(cnt_ext - CMP_W'(1));
            if (ok) begin
               fill_count_in = fill_count_ff - CNT_W'(1);
            end
         end
         alist_pkg::MODE_READ: begin
            ok         = (pos_ext != '0) && (pos_ext <= cnt_ext);
            rd_sel     = 1'b1;
            ctl.rd_idx = alist_pkg::IDX_MAX_W'(pos_ext - CMP_W'(1));
         end
         alist_pkg::MODE_INSERT: begin
            ok         = (cnt_ext < depth_ext) && (pos_ext != '0)
                         && (pos_ext <= cnt_ext + CMP_W'(1));
            ctl.wr_idx = alist_pkg::IDX_MAX_W'(pos_ext - CMP_W'(1));
            if (ok) begin
               fill_count_in = fill_count_ff + CNT_W'(1);
            end
         end
         default: begin
            ok = 1'b0;
         end
      endcase
      ctl.wr = req_accept && ok && !rd_sel;
      if (!req_accept) begin
         fill_count_in = fill_count_ff;
      end
   end

   genvar gi;
   generate
      for (gi = 0; gi < DEPTH; gi++) begin : g_cell
         if (gi == 0) begin : g_head
            alist_cell #(
               .CELL_INDEX (gi)
            ) u_cell (
               .clock     (clock),
               .ctl       (ctl),
               .wr_data   (req_value),
               .shift_in  ('0),
               .entry_out (cell_entry[gi]),
               .rd_data   (cell_rd[gi])
            );
         end else begin : g_body
            alist_cell #(
               .CELL_INDEX (gi)
            ) u_cell (
               .clock     (clock),
               .ctl       (ctl),
               .wr_data   (req_value),
               .shift_in  (cell_entry[gi-1]),
               .entry_out (cell_entry[gi]),
               .rd_data   (cell_rd[gi])
            );
         end
      end
   endgenerate

   always_comb begin
      rd_or = '0;
      for (int i = 0; i < DEPTH; i++) begin
         rd_or = rd_or | cell_rd[i];
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_ok_in    = rsp_ok_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_count_in = rsp_count_ff;
      if (req_accept) begin
         rsp_valid_in = 1'b1;
         rsp_ok_in    = ok;
         rsp_data_in  = (ok && rd_sel) ? rd_or : '0;
         rsp_count_in = alist_pkg::COUNT_W'(fill_count_in);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_count_ff <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         fill_count_ff <= fill_count_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ok_ff    <= rsp_ok_in;
      rsp_data_ff  <= rsp_data_in;
      rsp_count_ff <= rsp_count_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_ok    = rsp_ok_ff;
   assign rsp_data  = rsp_data_ff;
   assign rsp_count = rsp_count_ff;

`ifndef SYNTHESIS
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      CMP_W'(fill_count_ff) <= CMP_W'(DEPTH))
      else $error("fill count above capacity");

   a_accept_resp: assert property (@(posedge clock) disable iff (reset)
      req_accept |=> rsp_valid_ff)
      else $error("accepted transaction produced no response");

   a_fail_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_ok_ff) |-> (rsp_data_ff == '0))
      else $error("failed response carries nonzero data");

   a_count_hold: assert property (@(posedge clock) disable iff (reset)
      !req_accept |=> $stable(fill_count_ff))
      else $error("fill count moved without a transaction");
`endif

endmodule

[src/alist_cell.sv]
module alist_cell #(
   parameter int CELL_INDEX = 0
) (
   input  logic                                clock,
   input  alist_pkg::cell_ctl_type             ctl,
   input  logic signed [alist_pkg::WORD_W-1:0] wr_data,
   input  logic signed [alist_pkg::WORD_W-1:0] shift_in,
   output logic signed [alist_pkg::WORD_W-1:0] entry_out,
   output logic signed [alist_pkg::WORD_W-1:0] rd_data
);

   localparam logic [alist_pkg::IDX_MAX_W-1:0] MY_IDX = alist_pkg::IDX_MAX_W'(CELL_INDEX);

   logic signed [alist_pkg::WORD_W-1:0] entry_ff;
   logic signed [alist_pkg::WORD_W-1:0] entry_in;

   always_comb begin
      entry_in = entry_ff;
      if (ctl.wr && (ctl.wr_idx == MY_IDX)) begin
         entry_in = wr_data;
      end else if (ctl.wr && (ctl.wr_idx < MY_IDX)) begin
         entry_in = shift_in;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

   assign entry_out = entry_ff;
   assign rd_data   = (ctl.rd_idx == MY_IDX) ? entry_ff : '0;

endmodule
